// ----- hw/rtl/sbkd_pkg.sv -----
// Shared types and constants for the star banner keyword detector.
// No dependencies; imported by every module of the block.
package sbkd_pkg;

  localparam int HIST_CELLS = 5;
  localparam int WORD_COUNT = 4;
  localparam int WORD_MAX = 6;

  localparam logic [7:0] STAR_CHAR = 8'h2A;
  localparam logic [3:0] MIN_STARS_RESET = 4'd3;
  localparam logic [7:0] WINDOW_LEN_RESET = 8'd48;
  localparam logic [7:0] SINCE_CLOSED = 8'd255;
  localparam logic [3:0] STAR_RUN_MAX = 4'd15;

  typedef enum logic [0:0] {
    CFG_MIN_STARS = 1'b0,
    CFG_WINDOW_LEN = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic advance;
    logic clear;
  } step_ctl_t;

  localparam logic [7:0] WORD_TEXT [WORD_COUNT][WORD_MAX] = '{
    '{8'h64, 8'h69, 8'h65, 8'h64, 8'h00, 8'h00},
    '{8'h6B, 8'h69, 8'h6C, 8'h6C, 8'h65, 8'h64},
    '{8'h64, 8'h65, 8'h61, 8'h74, 8'h68, 8'h00},
    '{8'h73, 8'h63, 8'h68, 8'h6F, 8'h6F, 8'h6C}
  };
  localparam int WORD_LEN [WORD_COUNT] = '{4, 6, 5, 6};

endpackage

// ----- hw/rtl/sbkd_cell.sv -----
// One history cell: a folded text byte and its in-window flag.
// Depends on sbkd_pkg for the step control struct.
module sbkd_cell
  import sbkd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  step_ctl_t  ctl,
  input  logic [7:0] d_byte,
  input  logic       d_win,
  output logic [7:0] q_byte,
  output logic       q_win
);

  logic [7:0] hold_byte;
  logic       hold_win;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      hold_byte <= 8'd0;
      hold_win  <= 1'b0;
    end else if (ctl.advance) begin
      hold_byte <= d_byte;
      hold_win  <= d_win;
    end
  end

  assign q_byte = hold_byte;
  assign q_win  = hold_win;

endmodule

// ----- hw/rtl/sbkd_banner.sv -----
// Star run counter and window position tracker.
// Depends on sbkd_pkg for constants and the step control struct.
module sbkd_banner
  import sbkd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  step_ctl_t  ctl,
  input  logic       is_star,
  input  logic [3:0] min_stars,
  input  logic [7:0] window_len,
  output logic       win
);

  logic [3:0] star_run;
  logic [3:0] star_run_next;
  logic [7:0] since_banner;
  logic [7:0] since_banner_next;
  logic [7:0] since_inc;

  assign since_inc = (since_banner == SINCE_CLOSED) ? since_banner : since_banner + 8'd1;

  always_comb begin
    if (is_star) begin
      star_run_next     = (star_run == STAR_RUN_MAX) ? star_run : star_run + 4'd1;
      since_banner_next = since_inc;
    end else begin
      star_run_next = 4'd0;
      if (star_run != 4'd0 && star_run >= min_stars) begin
        since_banner_next = 8'd0;
      end else begin
        since_banner_next = since_inc;
      end
    end
  end

  assign win = since_banner_next < window_len;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      star_run     <= 4'd0;
      since_banner <= SINCE_CLOSED;
    end else if (ctl.advance) begin
      star_run     <= star_run_next;
      since_banner <= since_banner_next;
    end
  end

endmodule

// ----- hw/rtl/star_banner_keyword_detector.sv -----
// Top level of the star banner keyword detector.
// Depends on sbkd_pkg, sbkd_banner and sbkd_cell.
//
// Takes one text byte per clock with no gaps of its own. The result word for a
// text appears in the cycle after the byte marked last is accepted, from an output
// register; input is held off only while that register holds a word that the
// consumer stalls. Each byte before a NUL is matched as it arrives against a
// row of five history cells, which shifts one byte per cycle unless held off.
module star_banner_keyword_detector
  import sbkd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] text_byte,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       event_res
);

  logic [3:0] min_stars;
  logic [7:0] window_len;
  logic       found;
  logic       text_ended;
  logic       accept;
  logic       take;
  logic       new_win;
  logic [7:0] new_byte;
  logic [WORD_COUNT-1:0] word_hit;
  logic       hit;
  step_ctl_t  ctl;

  logic [7:0] cell_byte [HIST_CELLS];
  logic       cell_win  [HIST_CELLS];

  always_ff @(posedge clk) begin
    if (rst) begin
      min_stars  <= MIN_STARS_RESET;
      window_len <= WINDOW_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_MIN_STARS:  min_stars  <= cfg_data[3:0];
        CFG_WINDOW_LEN: window_len <= cfg_data;
      endcase
    end
  end

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign take     = accept && !text_ended && (text_byte != 8'd0);
  assign new_byte = (text_byte >= 8'h41 && text_byte <= 8'h5A) ? text_byte + 8'h20
                                                                : text_byte;
  assign ctl.advance = take;
  assign ctl.clear   = accept && last;

  sbkd_banner u_banner (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .is_star    (text_byte == STAR_CHAR),
    .min_stars  (min_stars),
    .window_len (window_len),
    .win        (new_win)
  );

  for (genvar c = 0; c < HIST_CELLS; c++) begin : g_cell
    if (c == 0) begin : g_head
      sbkd_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .ctl    (ctl),
        .d_byte (new_byte),
        .d_win  (new_win),
        .q_byte (cell_byte[c]),
        .q_win  (cell_win[c])
      );
    end else begin : g_tail
      sbkd_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .ctl    (ctl),
        .d_byte (cell_byte[c-1]),
        .d_win  (cell_win[c-1]),
        .q_byte (cell_byte[c]),
        .q_win  (cell_win[c])
      );
    end
  end

  // word start sits len-1 positions back; position 0 is the incoming byte
  for (genvar w = 0; w < WORD_COUNT; w++) begin : g_word
    localparam int Len = WORD_LEN[w];
    logic [WORD_MAX-1:0] char_ok;
    for (genvar k = 0; k < WORD_MAX; k++) begin : g_char
      localparam int Pos = Len - 1 - k;
      if (k >= Len) begin : g_pad
        assign char_ok[k] = 1'b1;
      end else if (Pos == 0) begin : g_new
        assign char_ok[k] = (new_byte == WORD_TEXT[w][k]);
      end else begin : g_old
        assign char_ok[k] = (cell_byte[Pos-1] == WORD_TEXT[w][k]);
      end
    end
    assign word_hit[w] = cell_win[Len-2] && (&char_ok);
  end

  assign hit = take && (|word_hit);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      found      <= 1'b0;
      text_ended <= 1'b0;
    end else if (accept) begin
      if (hit) begin
        found <= 1'b1;
      end
      if (!text_ended && text_byte == 8'd0) begin
        text_ended <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last) begin
      event_res <= found || hit;
    end
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Testbench for star_banner_keyword_detector: directed texts, then random texts
// with star banners and keywords, checked word by word against a local model.
// Depends on sbkd_pkg and the detector RTL.
module tb;
  import sbkd_pkg::*;

  localparam int HOLD_CYCLES = 150;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 130;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [0:0] cfg_index = CFG_MIN_STARS;
  logic [7:0] cfg_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] text_byte = 8'h00;
  logic       last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       event_res;

  star_banner_keyword_detector DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .text_byte(text_byte), .last(last),
    .out_valid(out_valid), .out_stall(out_stall), .event_res(event_res)
  );

  always #6 clk = ~clk;

  string kw [4] = '{"died", "killed", "death", "school"};

  // scanner model state
  logic [3:0] min_stars_r = MIN_STARS_RESET;
  logic [7:0] win_len_r = WINDOW_LEN_RESET;
  logic [3:0] run_len = 4'd0;
  logic [7:0] since_cnt = SINCE_CLOSED;
  logic [7:0] hist_byte [6];
  logic       hist_win [6];
  logic       hit_seen = 1'b0;
  logic       nul_seen = 1'b0;

  logic       verdict_q [$];
  logic [7:0] pend_txt [$];
  logic       want_res;
  int         err_cnt = 0;
  int         fed_cnt = 0;
  bit         idle_on = 1'b1;
  bit         hold_req = 1'b0;

  // directed texts; verdict -1 means take the model's answer
  string probe_txt [5] = '{"\377", "***KILLED", "**died", "***_died", "x****"};
  int    probe_nul [5] = '{-1, -1, -1, 3, -1};
  int    probe_verdict [5] = '{0, 1, 0, 0, 0};

  task automatic flag_error(input string msg);
    err_cnt++;
    $display("tb: mismatch: %s", msg);
  endtask

  task automatic clear_scan();
    run_len = 4'd0;
    since_cnt = SINCE_CLOSED;
    for (int i = 0; i < 6; i++) begin
      hist_byte[i] = 8'h00;
      hist_win[i] = 1'b0;
    end
    hit_seen = 1'b0;
    nul_seen = 1'b0;
  endtask

  task automatic scan_word(input logic [7:0] b, input logic l);
    int len;
    bit hit;
    logic [7:0] ch;
    if (!nul_seen) begin
      if (b == 8'h00) begin
        nul_seen = 1'b1;
      end else begin
        if (b == STAR_CHAR) begin
          if (run_len != STAR_RUN_MAX) run_len++;
          if (since_cnt != SINCE_CLOSED) since_cnt++;
        end else begin
          if (run_len != 4'd0 && run_len >= min_stars_r) since_cnt = 8'd0;
          else if (since_cnt != SINCE_CLOSED) since_cnt++;
          run_len = 4'd0;
        end
        for (int i = 5; i > 0; i--) begin
          hist_byte[i] = hist_byte[i-1];
          hist_win[i] = hist_win[i-1];
        end
        hist_byte[0] = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
        hist_win[0] = (since_cnt < win_len_r);
        for (int w = 0; w < 4; w++) begin
          len = kw[w].len();
          if (hist_win[len-1]) begin
            hit = 1'b1;
            for (int k = 0; k < len; k++) begin
              ch = kw[w][k];
              if (hist_byte[len-1-k] != ch) hit = 1'b0;
            end
            if (hit) hit_seen = 1'b1;
          end
        end
      end
    end
    if (l) begin
      verdict_q.push_back(hit_seen);
      clear_scan();
    end
  endtask

  task automatic send_word(input logic [7:0] b, input logic l, input int forced);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    text_byte <= b;
    last <= l;
    do @(posedge clk); while (in_stall);
    scan_word(b, l);
    if (l && forced >= 0) verdict_q[verdict_q.size()-1] = forced[0];
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_pair(input logic [3:0] ms, input logic [7:0] wl);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MIN_STARS;
    cfg_data <= {4'($urandom_range(0, 15)), ms};
    @(posedge clk);
    min_stars_r = ms;
    cfg_index <= CFG_WINDOW_LEN;
    cfg_data <= wl;
    @(posedge clk);
    win_len_r = wl;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] noise_byte();
    string pool = "dieklathsco*DKS";
    if ($urandom_range(0, 1)) return pool[$urandom_range(0, pool.len() - 1)];
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic make_text();
    int kind, nseg, runl, fill, wl, w, cut;
    logic [7:0] ch;
    pend_txt.delete();
    kind = $urandom_range(0, 9);
    wl = win_len_r;
    nseg = (kind == 4) ? 2 : 1;
    repeat ($urandom_range(0, 3)) pend_txt.push_back(noise_byte());
    if (kind != 0) begin
      for (int s = 0; s < nseg; s++) begin
        runl = int'(min_stars_r) + int'($urandom_range(0, 3)) - 2;
        if (runl < 1) runl = 1;
        if ($urandom_range(0, 15) == 0) runl = $urandom_range(15, 20);
        repeat (runl) pend_txt.push_back(STAR_CHAR);
        if (wl >= 200 && $urandom_range(0, 29) == 0) fill = $urandom_range(wl - 3, wl + 3);
        else fill = $urandom_range(0, (wl < 10) ? wl + 1 : 10);
        repeat (fill) pend_txt.push_back(noise_byte());
        w = $urandom_range(0, 3);
        cut = (kind == 2) ? $urandom_range(0, kw[w].len() - 1) : -1;
        for (int k = 0; k < kw[w].len(); k++) begin
          ch = kw[w][k];
          if (k == cut) ch = noise_byte();
          else if ($urandom_range(0, 1)) ch = ch - 8'h20;
          pend_txt.push_back(ch);
        end
      end
      if (kind == 6) void'(pend_txt.pop_back());
    end
    if (kind != 5 && kind != 6) repeat ($urandom_range(0, 3)) pend_txt.push_back(noise_byte());
    if (pend_txt.size() == 0) pend_txt.push_back(noise_byte());
    if (kind == 3) pend_txt[$urandom_range(0, pend_txt.size() - 1)] = 8'h00;
  endtask

  task automatic feed_text();
    bit dead;
    dead = 1'b0;
    for (int k = 0; k < pend_txt.size(); k++) begin
      if (!dead) fed_cnt++;
      if (pend_txt[k] == 8'h00) dead = 1'b1;
      send_word(pend_txt[k], k == pend_txt.size() - 1, -1);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        flag_error("result word with nothing pending");
      end else begin
        want_res = verdict_q.pop_front();
        if (event_res !== want_res)
          flag_error($sformatf("event_res %b, want %b", event_res, want_res));
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #(64'd5_000_000);
    $display("tb: done, errors");
    $finish;
  end

  logic [3:0] set_ms [8] = '{4'd1, 4'd15, 4'd2, 4'd0, 4'd4, 4'd3, 4'd7, 4'd15};
  logic [7:0] set_wl [8] = '{8'd1, 8'd255, 8'd4, 8'd0, 8'd10, 8'd48, 8'd6, 8'd1};

  initial begin
    logic [3:0] ms;
    logic [7:0] wl;
    int n, goal;
    logic [7:0] b;
    clear_scan();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < 5; r++) begin
      n = probe_txt[r].len();
      for (int k = 0; k < n; k++) begin
        b = (k == probe_nul[r]) ? 8'h00 : probe_txt[r][k];
        send_word(b, k == n - 1, probe_verdict[r]);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      if (ph < 8) begin
        ms = set_ms[ph];
        wl = set_wl[ph];
      end else begin
        ms = $urandom_range(1, 15);
        wl = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 20);
      end
      cfg_pair(ms, wl);
      idle_on = (ph < PHASES - 1);
      if (ph == 2) hold_req = 1'b1;
      goal = fed_cnt + PHASE_ITEMS;
      while (fed_cnt < goal) begin
        make_text();
        feed_text();
      end
    end

    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
